// ----- rtl/gbns_pkg.sv -----
// ----------------------------------------------------------------------------
// gbns_pkg: shared types for the grid next-step planner
// Beat payloads, controller commands, datapath status and step offsets.
// ----------------------------------------------------------------------------
`default_nettype none

package gbns_pkg;

    typedef struct packed {
        logic       req_type;
        logic [4:0] tile_row;
        logic [4:0] tile_col;
        logic [1:0] tile_kind;
        logic [9:0] start_x;
        logic [9:0] start_y;
        logic [9:0] target_x;
        logic [9:0] target_y;
    } t_req;

    typedef struct packed {
        logic       direct_mode;
        logic [4:0] next_row;
        logic [4:0] next_col;
        logic       moved;
    } t_rsp;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] KIND_OPEN = 2'd0;

    localparam int STEPS = 8;

    // neighbor order: N, S, W, E, NW, NE, SW, SE
    localparam logic signed [1:0] STEP_DR [STEPS] =
        '{-2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd1, 2'sd1};
    localparam logic signed [1:0] STEP_DC [STEPS] =
        '{2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1};

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_PREP1  = 13'b0000000000100,
        S_PREP2  = 13'b0000000001000,
        S_DCLR   = 13'b0000000010000,
        S_SEED   = 13'b0000000100000,
        S_DEQ    = 13'b0000001000000,
        S_CUR    = 13'b0000010000000,
        S_CURD   = 13'b0000100000000,
        S_EXPAND = 13'b0001000000000,
        S_FSTART = 13'b0010000000000,
        S_FIN    = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    typedef struct packed {
        logic clear_tile;
        logic idle;
        logic prep1;
        logic prep2;
        logic dclr;
        logic seed;
        logic deq;
        logic cur;
        logic curd;
        logic expand;
        logic fstart;
        logic fin;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic sweep_done;
        logic queue_empty;
        logic cur_is_start;
        logic k_last;
        logic direct;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/gbns_if.sv -----
// ----------------------------------------------------------------------------
// gbns_if: request and response channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbns_req_if import gbns_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface gbns_rsp_if import gbns_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/grid_bfs_next_step_unit.sv -----
// ----------------------------------------------------------------------------
// grid_bfs_next_step_unit: next-tile planner on a tile grid
// Holds a grid of tile kinds and answers next-step queries by an 8-connected
// breadth-first search from the target tile.
//
// Channels: i_req carries write beats (req_type 0, one tile kind, no
// response) and query beats (req_type 1, start and target pixel positions,
// one response beat on o_rsp).
// Queries: a write is stored as it is accepted. A query in direct mode
// skips the search. A searched query first clears the distance store in a
// pass over all CELLS tiles, where CELLS = GRID_ROWS * GRID_COLS, and its
// search time is set by the single read port of the distance memory. One
// query is in flight at a time.
// Reset: a clearing pass over all CELLS tiles sets every tile open; i_req.ready
// stays low until it ends.
// Stall: the response sits in an output register until taken; the block
// accepts the next beat meanwhile, and holds a later response until the
// register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_bfs_next_step_unit import gbns_pkg::*; #(
    parameter int GRID_ROWS   = 32,
    parameter int GRID_COLS   = 32,
    parameter int TILE_PIXELS = 32
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    gbns_req_if.sink   i_req,
    gbns_rsp_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    gbns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_query (i_req.data.req_type == REQ_QUERY),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gbns_dp #(
        .GRID_ROWS   (GRID_ROWS),
        .GRID_COLS   (GRID_COLS),
        .TILE_PIXELS (TILE_PIXELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req_valid (i_req.valid),
        .i_req_data  (i_req.data),
        .i_out_ready (o_rsp.ready),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp.valid),
        .o_rsp_data  (o_rsp.data)
    );

    assign i_req.ready = cmd.idle;

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_tile |-> !i_req.ready)
        else $error("beat accepted during tile clear");

    a_write_no_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready && (i_req.data.req_type == REQ_WRITE)
        |=> !cmd.load_out && !cmd.prep1)
        else $error("write beat started a query");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_rsp.valid || o_rsp.ready))
        else $error("response overwritten");

    a_direct_unmoved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.direct_mode |-> !o_rsp.data.moved)
        else $error("direct response marked moved");

endmodule

`default_nettype wire

// ----- rtl/gbns_ctrl.sv -----
// ----------------------------------------------------------------------------
// gbns_ctrl: sequencer for the grid next-step planner
// Steps through clear, prepare, search and neighbor selection phases.
// ----------------------------------------------------------------------------
`default_nettype none

module gbns_ctrl import gbns_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_req_valid,
    input  wire  i_req_query,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (i_sts.sweep_done) n_state = S_IDLE;
            S_IDLE:   if (i_req_valid && i_req_query) n_state = S_PREP1;
            S_PREP1:  n_state = S_PREP2;
            S_PREP2:  n_state = i_sts.direct ? S_OUT : S_DCLR;
            S_DCLR:   if (i_sts.sweep_done) n_state = S_SEED;
            S_SEED:   n_state = S_DEQ;
            S_DEQ:    n_state = i_sts.queue_empty ? S_FSTART : S_CUR;
            S_CUR:    n_state = S_CURD;
            S_CURD:   n_state = i_sts.cur_is_start ? S_FSTART : S_EXPAND;
            S_EXPAND: if (i_sts.k_last) n_state = S_DEQ;
            S_FSTART: n_state = S_FIN;
            S_FIN:    if (i_sts.k_last) n_state = S_OUT;
            S_OUT:    if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd.clear_tile = (r_state == S_CLEAR);
        o_cmd.idle       = (r_state == S_IDLE);
        o_cmd.prep1      = (r_state == S_PREP1);
        o_cmd.prep2      = (r_state == S_PREP2);
        o_cmd.dclr       = (r_state == S_DCLR);
        o_cmd.seed       = (r_state == S_SEED);
        o_cmd.deq        = (r_state == S_DEQ);
        o_cmd.cur        = (r_state == S_CUR);
        o_cmd.curd       = (r_state == S_CURD);
        o_cmd.expand     = (r_state == S_EXPAND);
        o_cmd.fstart     = (r_state == S_FSTART);
        o_cmd.fin        = (r_state == S_FIN);
        o_cmd.load_out   = (r_state == S_OUT) && i_sts.out_free;
    end

endmodule

`default_nettype wire

// ----- rtl/gbns_dp.sv -----
// ----------------------------------------------------------------------------
// gbns_dp: datapath for the grid next-step planner
// Tile, distance and queue memories, tile math, search and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gbns_dp import gbns_pkg::*; #(
    parameter int GRID_ROWS   = 32,
    parameter int GRID_COLS   = 32,
    parameter int TILE_PIXELS = 32
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  t_cmd i_cmd,
    input  wire  i_req_valid,
    input  t_req i_req_data,
    input  wire  i_out_ready,
    output t_sts o_sts,
    output logic o_rsp_valid,
    output t_rsp o_rsp_data
);

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int CW    = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CLW   = $clog2(GRID_COLS);
    localparam int SH    = 20;
    localparam int RECIP = ((1 << SH) + TILE_PIXELS - 1) / TILE_PIXELS;
    localparam int TSQ   = TILE_PIXELS * TILE_PIXELS;
    localparam int DW    = 11;

    typedef struct packed {
        logic          valid;
        logic [DW-1:0] hops;
    } t_dent;

    typedef struct packed {
        logic [RW-1:0]  r;
        logic [CLW-1:0] c;
    } t_qent;

    function automatic logic [CW-1:0] f_idx(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return CW'(r * CW'(GRID_COLS)) + c;
    endfunction

    function automatic logic [10:0] f_quot(input logic [9:0] pix);
        logic [30:0] prod;
        prod = 31'(pix) * 31'(RECIP);
        return prod[SH+10:SH];
    endfunction

    logic [1:0]   tile_mem [CELLS];
    t_dent        dist_mem [CELLS];
    t_qent        q_mem    [CELLS];

    t_req           r_req;
    logic [RW-1:0]  r_sr, r_tr, r_br, r_best_r;
    logic [CLW-1:0] r_sc, r_tc, r_bc, r_best_c;
    logic [19:0]    r_dx2, r_dy2;
    logic           r_direct;
    logic [CW-1:0]  r_sw;
    logic [CW:0]    r_head, r_tail;
    logic [DW-1:0]  r_curd, r_best_d;
    logic           r_best_v;
    logic [3:0]     r_k;
    logic           r_pn_ok;
    logic [CW-1:0]  r_pn_idx;
    logic [RW-1:0]  r_pn_r;
    logic [CLW-1:0] r_pn_c;
    logic [1:0]     r_tile_rd;
    t_dent          r_dist_rd;
    t_qent          r_q_rd;
    logic           r_ov;
    t_rsp           r_od;

    logic                accept;
    logic                wr_in;
    logic [10:0]         q_sx, q_sy, q_tx, q_ty;
    logic signed [10:0]  dx, dy;
    logic signed [21:0]  dx_sq, dy_sq;
    logic [20:0]         dsq;
    logic                is_direct;
    logic signed [RW+1:0]  nr;
    logic signed [CLW+1:0] nc;
    logic                nb_ok;
    logic [CW-1:0]       nb_idx;
    logic [CW-1:0]       dist_raddr;
    logic                take_nb;
    t_dent               new_ent;

    assign accept = i_cmd.idle && i_req_valid;
    assign wr_in  = accept && (i_req_data.req_type == REQ_WRITE)
                    && (9'(i_req_data.tile_row) < 9'(GRID_ROWS))
                    && (9'(i_req_data.tile_col) < 9'(GRID_COLS));

    assign q_sx  = f_quot(r_req.start_x);
    assign q_sy  = f_quot(r_req.start_y);
    assign q_tx  = f_quot(r_req.target_x);
    assign q_ty  = f_quot(r_req.target_y);
    assign dx    = $signed({1'b0, r_req.target_x}) - $signed({1'b0, r_req.start_x});
    assign dy    = $signed({1'b0, r_req.target_y}) - $signed({1'b0, r_req.start_y});
    assign dx_sq = dx * dx;
    assign dy_sq = dy * dy;
    assign dsq   = 21'(r_dx2) + 21'(r_dy2);
    assign is_direct = (dsq < 21'(TSQ)) || (r_sr == r_tr && r_sc == r_tc);

    assign nr     = $signed({2'b00, r_br}) + $signed({{RW{STEP_DR[r_k[2:0]][1]}},
                                                       STEP_DR[r_k[2:0]]});
    assign nc     = $signed({2'b00, r_bc}) + $signed({{CLW{STEP_DC[r_k[2:0]][1]}},
                                                       STEP_DC[r_k[2:0]]});
    assign nb_ok  = !r_k[3] && !nr[RW+1] && !nc[CLW+1]
                    && (nr[RW:0] < (RW+1)'(GRID_ROWS))
                    && (nc[CLW:0] < (CLW+1)'(GRID_COLS));
    assign nb_idx = f_idx(CW'(nr[RW-1:0]), CW'(nc[CLW-1:0]));

    always_comb begin
        priority if (i_cmd.cur) begin
            dist_raddr = f_idx(CW'(r_q_rd.r), CW'(r_q_rd.c));
        end else if (i_cmd.fstart) begin
            dist_raddr = f_idx(CW'(r_sr), CW'(r_sc));
        end else begin
            dist_raddr = nb_idx;
        end
    end

    assign take_nb = i_cmd.expand && r_pn_ok && (r_tile_rd == KIND_OPEN)
                     && !r_dist_rd.valid && (r_tail < (CW+1)'(CELLS));
    assign new_ent = '{valid: 1'b1, hops: r_curd + DW'(1)};

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_tile) begin
            tile_mem[r_sw] <= KIND_OPEN;
        end else if (wr_in) begin
            tile_mem[f_idx(CW'(i_req_data.tile_row), CW'(i_req_data.tile_col))]
                <= i_req_data.tile_kind;
        end
        r_tile_rd <= tile_mem[nb_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dclr) begin
            dist_mem[r_sw] <= '0;
        end else if (i_cmd.seed) begin
            dist_mem[f_idx(CW'(r_tr), CW'(r_tc))] <= '{valid: 1'b1, hops: '0};
        end else if (take_nb) begin
            dist_mem[r_pn_idx] <= new_ent;
        end
        r_dist_rd <= dist_mem[dist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed) begin
            q_mem[0] <= '{r: r_tr, c: r_tc};
        end else if (take_nb) begin
            q_mem[r_tail[CW-1:0]] <= '{r: r_pn_r, c: r_pn_c};
        end
        r_q_rd <= q_mem[r_head[CW-1:0]];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req_data;
        end
        if (i_cmd.prep1) begin
            r_sr  <= (q_sy >= 11'(GRID_ROWS)) ? RW'(GRID_ROWS - 1) : q_sy[RW-1:0];
            r_sc  <= (q_sx >= 11'(GRID_COLS)) ? CLW'(GRID_COLS - 1) : q_sx[CLW-1:0];
            r_tr  <= (q_ty >= 11'(GRID_ROWS)) ? RW'(GRID_ROWS - 1) : q_ty[RW-1:0];
            r_tc  <= (q_tx >= 11'(GRID_COLS)) ? CLW'(GRID_COLS - 1) : q_tx[CLW-1:0];
            r_dx2 <= dx_sq[19:0];
            r_dy2 <= dy_sq[19:0];
        end
        if (i_cmd.prep2) begin
            r_direct <= is_direct;
        end
        if (i_cmd.cur) begin
            r_br <= r_q_rd.r;
            r_bc <= r_q_rd.c;
        end else if (i_cmd.fstart) begin
            r_br <= r_sr;
            r_bc <= r_sc;
        end
        if (i_cmd.curd) begin
            r_curd <= r_dist_rd.hops;
        end
        r_pn_idx <= nb_idx;
        r_pn_r   <= nr[RW-1:0];
        r_pn_c   <= nc[CLW-1:0];
        if (i_cmd.fin) begin
            if (r_k == 4'd0) begin
                r_best_v <= r_dist_rd.valid;
                r_best_d <= r_dist_rd.hops;
                r_best_r <= r_sr;
                r_best_c <= r_sc;
            end else if (r_pn_ok && (r_tile_rd == KIND_OPEN) && r_dist_rd.valid
                         && (!r_best_v || (r_dist_rd.hops < r_best_d))) begin
                r_best_v <= 1'b1;
                r_best_d <= r_dist_rd.hops;
                r_best_r <= r_pn_r;
                r_best_c <= r_pn_c;
            end
        end
        if (i_cmd.load_out) begin
            if (r_direct) begin
                r_od <= '{direct_mode: 1'b1, next_row: 5'(r_sr), next_col: 5'(r_sc),
                          moved: 1'b0};
            end else begin
                r_od <= '{direct_mode: 1'b0, next_row: 5'(r_best_r),
                          next_col: 5'(r_best_c),
                          moved: (r_best_r != r_sr) || (r_best_c != r_sc)};
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw    <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_k     <= '0;
            r_pn_ok <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.clear_tile || i_cmd.dclr) begin
                r_sw <= o_sts.sweep_done ? '0 : r_sw + CW'(1);
            end
            if (i_cmd.seed) begin
                r_head <= '0;
                r_tail <= (CW+1)'(1);
            end else begin
                if (i_cmd.deq && !o_sts.queue_empty) begin
                    r_head <= r_head + (CW+1)'(1);
                end
                if (take_nb) begin
                    r_tail <= r_tail + (CW+1)'(1);
                end
            end
            if (i_cmd.curd || i_cmd.fstart) begin
                r_k <= '0;
            end else if ((i_cmd.expand || i_cmd.fin) && !r_k[3]) begin
                r_k <= r_k + 4'd1;
            end
            r_pn_ok <= (i_cmd.expand || i_cmd.fin) && nb_ok;
            if (i_cmd.load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_sts.sweep_done   = (r_sw == CW'(CELLS - 1));
    assign o_sts.queue_empty  = (r_head >= r_tail);
    assign o_sts.cur_is_start = (r_br == r_sr) && (r_bc == r_sc);
    assign o_sts.k_last       = r_k[3];
    assign o_sts.direct       = is_direct;
    assign o_sts.out_free     = !r_ov || i_out_ready;

    assign o_rsp_valid = r_ov;
    assign o_rsp_data  = r_od;

endmodule

`default_nettype wire

// ----- bench/tb_checker.sv -----
// ----------------------------------------------------------------------------
// tb_checker: next-step planner scoreboard
// Watches the request and response channels, keeps its own copy of the tile
// grid, predicts each query answer by a breadth-first search and compares
// every response beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_checker import gbns_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    gbns_req_if   req,
    gbns_rsp_if   rsp,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int ROWS  = 32;
    localparam int COLS  = 32;
    localparam int TILE  = 32;
    localparam int TILES = ROWS * COLS;

    logic [1:0]  grid_kind [TILES];
    logic [10:0] hop_count [TILES];
    bit          reached   [TILES];
    int          frontier  [TILES];
    t_rsp        answers_due[$];
    int          fail_count;

    function automatic int tile_of(logic [9:0] pix, int limit);
        int t;
        t = int'(pix) / TILE;
        return (t >= limit) ? limit - 1 : t;
    endfunction

    function automatic t_rsp plan_step(t_req r);
        int   sr, sc, tr, tc, dx, dy, head, tail, cur, nr, nc, ni;
        int   best_r, best_c;
        bit   best_ok;
        logic [10:0] best_d;
        t_rsp a;
        sr = tile_of(r.start_y, ROWS);
        sc = tile_of(r.start_x, COLS);
        tr = tile_of(r.target_y, ROWS);
        tc = tile_of(r.target_x, COLS);
        dx = int'(r.target_x) - int'(r.start_x);
        dy = int'(r.target_y) - int'(r.start_y);
        a.next_row = sr[4:0];
        a.next_col = sc[4:0];
        a.moved = 1'b0;
        if (dx * dx + dy * dy < TILE * TILE || (sr == tr && sc == tc)) begin
            a.direct_mode = 1'b1;
            return a;
        end
        a.direct_mode = 1'b0;
        foreach (reached[i]) reached[i] = 0;
        head = 0;
        tail = 0;
        hop_count[tr * COLS + tc] = '0;
        reached[tr * COLS + tc] = 1;
        frontier[tail++] = tr * COLS + tc;
        while (head < tail) begin
            cur = frontier[head++];
            if (cur / COLS == sr && cur % COLS == sc) break;
            for (int k = 0; k < STEPS; k++) begin
                nr = cur / COLS + int'(STEP_DR[k]);
                nc = cur % COLS + int'(STEP_DC[k]);
                if (nr < 0 || nr >= ROWS || nc < 0 || nc >= COLS) continue;
                ni = nr * COLS + nc;
                if (grid_kind[ni] == KIND_OPEN && !reached[ni] && tail < TILES) begin
                    hop_count[ni] = hop_count[cur] + 11'd1;
                    reached[ni] = 1;
                    frontier[tail++] = ni;
                end
            end
        end
        best_r = sr;
        best_c = sc;
        best_ok = reached[sr * COLS + sc];
        best_d = hop_count[sr * COLS + sc];
        for (int k = 0; k < STEPS; k++) begin
            nr = sr + int'(STEP_DR[k]);
            nc = sc + int'(STEP_DC[k]);
            if (nr < 0 || nr >= ROWS || nc < 0 || nc >= COLS) continue;
            ni = nr * COLS + nc;
            if (grid_kind[ni] == KIND_OPEN && reached[ni] &&
                (!best_ok || hop_count[ni] < best_d)) begin
                best_ok = 1;
                best_d = hop_count[ni];
                best_r = nr;
                best_c = nc;
            end
        end
        a.next_row = best_r[4:0];
        a.next_col = best_c[4:0];
        a.moved = (best_r != sr || best_c != sc);
        return a;
    endfunction

    initial begin
        foreach (grid_kind[i]) grid_kind[i] = KIND_OPEN;
        fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && req.valid && req.ready) begin
            if (req.data.req_type == REQ_WRITE)
                grid_kind[int'(req.data.tile_row) * COLS + int'(req.data.tile_col)] <=
                    req.data.tile_kind;
            else
                answers_due = {answers_due, plan_step(req.data)};
        end
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (answers_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("unexpected response beat %p", rsp.data);
            end else begin
                want = answers_due.pop_front();
                if (rsp.data.direct_mode !== want.direct_mode ||
                    rsp.data.next_row !== want.next_row ||
                    rsp.data.next_col !== want.next_col ||
                    rsp.data.moved !== want.moved) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected %p, got %p", want, rsp.data);
                end
            end
        end
    end

    assign o_fail_count = fail_count;
    assign o_pending = answers_due.size();

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: next-step planner testbench
// Drives tile writes and next-step queries, directed corner cases first and
// then random mazes, with random gaps and response stalls; the checker
// predicts and compares every answer.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import gbns_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    bit   calm;

    gbns_req_if req ();
    gbns_rsp_if rsp ();

    grid_bfs_next_step_unit u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    tb_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .req         (req),
        .rsp         (rsp),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 6000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // response stalls in bursts
    initial begin
        int n;
        rsp.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                rsp.ready <= 1'b0;
                repeat (n) @(negedge i_clk);
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic send(t_req r);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            @(negedge i_clk);
            req.valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req.valid <= 1'b1;
        req.data <= r;
        #1;
        while (!req.ready) begin
            @(negedge i_clk);
            #1;
        end
        @(posedge i_clk);
    endtask

    task automatic put_tile(int row, int col, logic [1:0] kind);
        t_req r;
        r = t_req'($bits(t_req)'({$urandom, $urandom}));
        r.req_type = REQ_WRITE;
        r.tile_row = row[4:0];
        r.tile_col = col[4:0];
        r.tile_kind = kind;
        send(r);
    endtask

    task automatic ask(int sx, int sy, int tx, int ty);
        t_req r;
        r = t_req'($bits(t_req)'({$urandom, $urandom}));
        r.req_type = REQ_QUERY;
        r.start_x = sx[9:0];
        r.start_y = sy[9:0];
        r.target_x = tx[9:0];
        r.target_y = ty[9:0];
        send(r);
    endtask

    initial begin
        int guard;
        calm = 1'b0;
        i_rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        ask(0, 0, 1023, 1023);
        ask(1023, 1023, 0, 0);
        ask(100, 100, 120, 110);
        ask(31, 31, 32, 32);
        ask(40, 40, 60, 63);
        put_tile(5, 5, 2'd1);
        put_tile(5, 6, 2'd2);
        put_tile(4, 6, 2'd3);
        ask(5 * 32 + 16, 5 * 32 + 16, 20 * 32, 20 * 32);
        ask(16, 16, 6 * 32 + 16, 5 * 32 + 16);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (i != 1 || j != 1) put_tile(i, j, 2'd1);
        ask(48, 48, 900, 900);
        ask(0, 0, 900, 900);
        ask(31 * 32, 31 * 32, 0, 31 * 32);
        put_tile(0, 0, 2'd0);
        put_tile(31, 31, 2'd3);

        guard = 0;
        while (pending != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (50) @(posedge i_clk);

        for (int k = 0; k < 80; k++) begin
            if (k > 64) calm = 1'b1;
            if ($urandom_range(0, 9) < 6) begin
                put_tile($urandom_range(0, 31), $urandom_range(0, 31),
                    ($urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 3)) : KIND_OPEN);
            end else if ($urandom_range(0, 7) == 0) begin
                send(t_req'($bits(t_req)'({$urandom, $urandom})));
            end else begin
                ask($urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 1023));
            end
        end
        @(negedge i_clk);
        req.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/gbns_pkg.sv
rtl/gbns_if.sv
rtl/gbns_ctrl.sv
rtl/gbns_dp.sv
rtl/grid_bfs_next_step_unit.sv
bench/tb_checker.sv
bench/tb_top.sv
